@@ rtl/cpu_busy_percent_from_counters_unit_macros.svh @@
// Assertion macros for the CPU busy share unit.
// Included by the RTL files that carry concurrent assertions; needs aclk and aresetn in scope.
`ifndef CPU_BUSY_PERCENT_FROM_COUNTERS_UNIT_MACROS_SVH
`define CPU_BUSY_PERCENT_FROM_COUNTERS_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define CBPC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cbpc assertion failed");
// Next-cycle implication.
`define CBPC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cbpc assertion failed");
`else
`define CBPC_ASSERT_IMP(lbl, ante, cons)
`define CBPC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ rtl/cbpc_pkg.sv @@
// Shared types and constants for the CPU busy share unit.
// No dependencies; imported by cbpc_alu and the top level.
package cbpc_pkg;

    localparam int TICK_W    = 64;
    localparam int NUM_TICKS = 8;
    localparam int ENTRY_W   = 6;
    localparam int BUSY_W    = 15;
    localparam int BUSY_MAX  = 25600;
    localparam int ALU_W     = 80;

    // 25600 = 2^14 + 2^13 + 2^10
    localparam int SHIFT_A   = 14;
    localparam int SHIFT_B   = 13;
    localparam int SHIFT_C   = 10;

    localparam int CNT_W     = 4;
    localparam int SUM_CNT_W = 3;

    localparam int S_TDATA_W = TICK_W * NUM_TICKS;
    localparam int S_TUSER_W = ENTRY_W;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = ENTRY_W + 1;

    // Input field order inside s_tdata, lowest first.
    localparam int F_IDLE    = 6;
    localparam int F_IOWAIT  = 7;

    typedef struct packed {
        logic             sub;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] result;
        logic             borrow;
    } alu_rsp_t;

    typedef struct packed {
        logic              primed;
        logic [TICK_W-1:0] total;
        logic [TICK_W-1:0] idle;
    } slot_t;

endpackage

@@ rtl/cbpc_alu.sv @@
// Shared add/subtract unit with borrow flag.
// Depends on cbpc_pkg for the request and response types.
module cbpc_alu
    import cbpc_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [ALU_W:0]   sum;
    logic [ALU_W-1:0] b_op;

    assign b_op = req.sub ? ~req.b : req.b;
    assign sum  = {1'b0, req.a} + {1'b0, b_op} + {{ALU_W{1'b0}}, req.sub};

    assign rsp.result = sum[ALU_W-1:0];
    assign rsp.borrow = req.sub & ~sum[ALU_W];

endmodule

@@ rtl/cpu_busy_percent_from_counters_unit.sv @@
// Busy share of a CPU from cumulative tick counters, one sample per beat. A primed, in-range
// entry runs 8 summing steps, 3 delta steps, 2 scaling steps and 15 restoring division
// steps, all on one shared 80-bit add/subtract unit, then an output step. s_tready stays low
// until the result moves to the output register, so one sample is handled at a time. A first
// sample stops after the first delta step, an out-of-range entry after the summing steps, and
// an empty or negative interval after the delta steps. The output step holds while the
// previous result waits on m_tready. After reset a clearing pass marks every entry unprimed;
// s_tready stays low during it. Depends on cbpc_pkg, cbpc_alu and the macros header.
`include "cpu_busy_percent_from_counters_unit_macros.svh"

module cpu_busy_percent_from_counters_unit
    import cbpc_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // user, nice, system, irq, softirq, steal, idle, iowait ticks (64 bits each)
    input  logic [S_TDATA_W-1:0] s_tdata,
    // entry
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // busy_percent, one zero pad bit
    output logic [M_TDATA_W-1:0] m_tdata,
    // entry_out, percent_valid
    output logic [M_TUSER_W-1:0] m_tuser
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int EXT_W = ((IDX_W > ENTRY_W) ? IDX_W : ENTRY_W) + 1;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SUM   = 4'd2;
    localparam logic [3:0] S_DTOT  = 4'd3;
    localparam logic [3:0] S_DIDLE = 4'd4;
    localparam logic [3:0] S_NUM   = 4'd5;
    localparam logic [3:0] S_MUL1  = 4'd6;
    localparam logic [3:0] S_MUL2  = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]   clr_cnt_reg, clr_cnt_next;

    slot_t              mem [ENTRIES];
    slot_t              rd_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    slot_t              mem_wdata;

    logic [TICK_W-1:0]  tick_reg [NUM_TICKS];
    logic [ENTRY_W-1:0] entry_reg;
    logic [IDX_W-1:0]   addr_reg;
    logic               in_range_reg;
    logic [EXT_W-1:0]   entry_ext;

    logic [TICK_W-1:0]  acc_reg;
    logic [TICK_W-1:0]  idle_sum_reg;
    logic [TICK_W-1:0]  dtot_reg;
    logic [TICK_W-1:0]  didle_reg;
    logic [TICK_W-1:0]  n_reg;
    logic [ALU_W-1:0]   num_reg;
    logic [TICK_W-1:0]  rem_reg;
    logic [BUSY_W-1:0]  lowq_reg;
    logic [BUSY_W-1:0]  res_busy_reg;
    logic               res_valid_reg;

    logic               m_tvalid_reg;
    logic [BUSY_W-1:0]  m_busy_reg;
    logic [ENTRY_W-1:0] m_entry_reg;
    logic               m_pvalid_reg;

    logic               s_accept;
    logic               out_free;
    logic               div_last;
    alu_req_t           alu_req;
    alu_rsp_t           alu_rsp;

    cbpc_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid & s_tready;
    assign out_free  = ~m_tvalid_reg | m_tready;
    assign entry_ext = EXT_W'(s_tuser);
    assign div_last  = (cnt_reg == CNT_W'(BUSY_W - 1));

    always_comb begin
        alu_req = '0;
        unique case (state_reg)
            S_SUM: begin
                alu_req.a = ALU_W'(acc_reg);
                alu_req.b = ALU_W'(tick_reg[cnt_reg[SUM_CNT_W-1:0]]);
            end
            S_DTOT: begin
                alu_req.sub = 1'b1;
                alu_req.a   = ALU_W'(acc_reg);
                alu_req.b   = ALU_W'(rd_reg.total);
            end
            S_DIDLE: begin
                alu_req.sub = 1'b1;
                alu_req.a   = ALU_W'(idle_sum_reg);
                alu_req.b   = ALU_W'(rd_reg.idle);
            end
            S_NUM: begin
                alu_req.sub = 1'b1;
                alu_req.a   = ALU_W'(dtot_reg);
                alu_req.b   = ALU_W'(didle_reg);
            end
            S_MUL1: begin
                alu_req.a = ALU_W'(n_reg) << SHIFT_A;
                alu_req.b = ALU_W'(n_reg) << SHIFT_B;
            end
            S_MUL2: begin
                alu_req.a = num_reg;
                alu_req.b = ALU_W'(n_reg) << SHIFT_C;
            end
            S_DIV: begin
                // trial remainder: shift in the next dividend bit, try subtracting the divisor
                alu_req.sub = 1'b1;
                alu_req.a   = ALU_W'({rem_reg, lowq_reg[BUSY_W-1]});
                alu_req.b   = ALU_W'(dtot_reg);
            end
            default: alu_req = '0;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            S_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(ENTRIES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_SUM;
                    cnt_next   = '0;
                end
            end
            S_SUM: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_TICKS - 1)) begin
                    state_next = in_range_reg ? S_DTOT : S_OUT;
                end
            end
            S_DTOT: begin
                state_next = rd_reg.primed ? S_DIDLE : S_OUT;
            end
            S_DIDLE: begin
                state_next = S_NUM;
            end
            S_NUM: begin
                // negative share or no elapsed ticks: report zero
                if (alu_rsp.borrow || dtot_reg == '0) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1: begin
                state_next = S_MUL2;
            end
            S_MUL2: begin
                state_next = S_DIV;
                cnt_next   = '0;
            end
            S_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (div_last) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        mem_we    = (state_reg == S_CLEAR) || (state_reg == S_DTOT);
        mem_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : addr_reg;
        if (state_reg == S_CLEAR) begin
            mem_wdata = '0;
        end else begin
            mem_wdata.primed = 1'b1;
            mem_wdata.total  = acc_reg;
            mem_wdata.idle   = idle_sum_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (s_accept) begin
            rd_reg <= mem[entry_ext[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            cnt_reg      <= '0;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            clr_cnt_reg <= clr_cnt_next;
            if (state_reg == S_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    for (int k = 0; k < NUM_TICKS - 2; k++) begin
                        tick_reg[k + 2] <= s_tdata[k*TICK_W +: TICK_W];
                    end
                    tick_reg[0]   <= s_tdata[F_IDLE*TICK_W +: TICK_W];
                    tick_reg[1]   <= s_tdata[F_IOWAIT*TICK_W +: TICK_W];
                    entry_reg     <= s_tuser;
                    addr_reg      <= entry_ext[IDX_W-1:0];
                    in_range_reg  <= (entry_ext < EXT_W'(ENTRIES));
                    acc_reg       <= '0;
                    res_busy_reg  <= '0;
                    res_valid_reg <= 1'b0;
                end
            end
            S_SUM: begin
                acc_reg <= alu_rsp.result[TICK_W-1:0];
                // idle and iowait come first: hold their sum
                if (cnt_reg == CNT_W'(1)) begin
                    idle_sum_reg <= alu_rsp.result[TICK_W-1:0];
                end
            end
            S_DTOT: begin
                dtot_reg <= alu_rsp.result[TICK_W-1:0];
                if (rd_reg.primed) begin
                    res_valid_reg <= 1'b1;
                end
            end
            S_DIDLE: begin
                didle_reg <= alu_rsp.result[TICK_W-1:0];
            end
            S_NUM: begin
                n_reg <= alu_rsp.result[TICK_W-1:0];
            end
            S_MUL1: begin
                num_reg <= alu_rsp.result;
            end
            S_MUL2: begin
                // upper part is already below the divisor since the quotient fits 15 bits
                rem_reg  <= alu_rsp.result[BUSY_W +: TICK_W];
                lowq_reg <= alu_rsp.result[BUSY_W-1:0];
            end
            S_DIV: begin
                if (alu_rsp.borrow) begin
                    rem_reg <= {rem_reg[TICK_W-2:0], lowq_reg[BUSY_W-1]};
                end else begin
                    rem_reg <= alu_rsp.result[TICK_W-1:0];
                end
                lowq_reg <= {lowq_reg[BUSY_W-2:0], ~alu_rsp.borrow};
                if (div_last) begin
                    res_busy_reg <= {lowq_reg[BUSY_W-2:0], ~alu_rsp.borrow};
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_busy_reg   <= res_busy_reg;
                    m_entry_reg  <= entry_reg;
                    m_pvalid_reg <= res_valid_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_busy_reg);
    assign m_tuser  = {m_pvalid_reg, m_entry_reg};

    `CBPC_ASSERT_IMP(a_busy_range, m_tvalid, m_tdata[BUSY_W-1:0] <= BUSY_W'(BUSY_MAX))
    `CBPC_ASSERT_IMP(a_busy_zero_unprimed, m_tvalid && !m_tuser[ENTRY_W], m_tdata == '0)
    `CBPC_ASSERT_IMP(a_rem_below_div, state_reg == S_DIV, rem_reg < dtot_reg)
    `CBPC_ASSERT_NXT(a_one_at_a_time, s_accept, !s_tready)
    `CBPC_ASSERT_IMP(a_result_from_seq, $rose(m_tvalid), $past(state_reg) == S_OUT)

endmodule
